// ===== src/cls_pkg.sv =====
// Shared types and constants for the circular list store.
// Used by cls_cell, cls_ctrl and circular_list_store; no dependencies.
package cls_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;
  localparam int IDXW     = $clog2(CAPACITY);
  localparam int CNTW     = $clog2(CAPACITY + 1);
  localparam int CMPW     = (POS_W > CNTW) ? POS_W : CNTW;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDXW-1:0]          idx_t;
  typedef logic [CNTW-1:0]          cnt_t;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_AFTER = 3'd1,
    CMD_INS_END   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DUMP      = 3'd5
  } cmd_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // Operation broadcast along the cell chain
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,     // cells above idx take left neighbor, cell idx loads data
    CH_SHIFT_DOWN, // every cell takes its right neighbor (the last cell takes the command data)
    CH_ROTATE      // cells below idx take right neighbor, cell idx loads data
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    idx_t      idx;
    data_t     data;
  } chain_cmd_t;

endpackage

// ===== src/cls_cell.sv =====
// One storage cell of the list chain: holds a single element.
// Depends on cls_pkg for the chain command struct.
module cls_cell (
  input  logic                clk,
  input  cls_pkg::chain_cmd_t cmd,
  input  cls_pkg::idx_t       cell_idx,
  input  cls_pkg::data_t      left_val,
  input  cls_pkg::data_t      right_val,
  output cls_pkg::data_t      val
);

  // Element register, no reset (payload)
  always_ff @(posedge clk) begin
    case (cmd.op)
      cls_pkg::CH_INSERT: begin
        if (cell_idx > cmd.idx) begin
          val <= left_val;
        end else if (cell_idx == cmd.idx) begin
          val <= cmd.data;
        end
      end
      cls_pkg::CH_SHIFT_DOWN: begin
        val <= right_val;
      end
      cls_pkg::CH_ROTATE: begin
        if (cell_idx < cmd.idx) begin
          val <= right_val;
        end else if (cell_idx == cmd.idx) begin
          val <= cmd.data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/cls_ctrl.sv =====
// Command decoder, fill count, dump sequencer and output register.
// Depends on cls_pkg; drives the chain command for the cls_cell row.
module cls_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cls_pkg::CMD_W-1:0] command,
  input  cls_pkg::data_t            value,
  input  logic [cls_pkg::POS_W-1:0] position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cls_pkg::STAT_W-1:0] status,
  output cls_pkg::data_t            element,
  output logic                      element_valid,
  output logic [cls_pkg::LEN_W-1:0] length,
  output logic                      final_res,
  input  cls_pkg::data_t            head_val,
  output cls_pkg::chain_cmd_t       chain_cmd
);

  cls_pkg::state_t state, state_next;
  cls_pkg::cnt_t   fill, fill_next;
  cls_pkg::cnt_t   dump_cnt, dump_cnt_next;

  logic              out_valid_next;
  cls_pkg::status_t  status_q, status_next;
  cls_pkg::data_t    element_next;
  logic              element_valid_next;
  logic              final_res_next;

  logic out_free;
  logic accept;
  logic is_full;
  logic is_empty;
  logic pos_bad;
  logic dump_last;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == cls_pkg::ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign is_full   = (fill == cls_pkg::CNTW'(cls_pkg::CAPACITY));
  assign is_empty  = (fill == '0);
  assign pos_bad   = (cls_pkg::CMPW'(position) >= cls_pkg::CMPW'(fill));
  assign dump_last = (dump_cnt == fill - cls_pkg::CNTW'(1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cls_pkg::ST_IDLE: begin
        if (accept && command == cls_pkg::CMD_DUMP && !is_empty) begin
          state_next = cls_pkg::ST_DUMP;
        end
      end
      cls_pkg::ST_DUMP: begin
        if (out_free && dump_last) begin
          state_next = cls_pkg::ST_IDLE;
        end
      end
      default: state_next = cls_pkg::ST_IDLE;
    endcase
  end

  // Datapath: chain command, fill, result register
  always_comb begin
    fill_next          = fill;
    dump_cnt_next      = dump_cnt;
    chain_cmd.op       = cls_pkg::CH_HOLD;
    chain_cmd.idx      = '0;
    chain_cmd.data     = value;
    out_valid_next     = out_valid && !out_ready;
    status_next        = status_q;
    element_next       = element;
    element_valid_next = element_valid;
    final_res_next     = final_res;

    case (state)
      cls_pkg::ST_IDLE: begin
        if (accept) begin
          status_next        = cls_pkg::STAT_OK;
          element_next       = '0;
          element_valid_next = 1'b0;
          final_res_next     = 1'b1;
          out_valid_next     = 1'b1;
          case (command)
            cls_pkg::CMD_INS_FRONT: begin
              if (is_full) begin
                status_next = cls_pkg::STAT_FULL;
              end else begin
                chain_cmd.op = cls_pkg::CH_INSERT;
                fill_next    = fill + cls_pkg::CNTW'(1);
              end
            end
            cls_pkg::CMD_INS_AFTER: begin
              if (is_full) begin
                status_next = cls_pkg::STAT_FULL;
              end else if (pos_bad) begin
                status_next = cls_pkg::STAT_RANGE;
              end else begin
                chain_cmd.op  = cls_pkg::CH_INSERT;
                chain_cmd.idx = cls_pkg::IDXW'(cls_pkg::CMPW'(position) + cls_pkg::CMPW'(1));
                fill_next     = fill + cls_pkg::CNTW'(1);
              end
            end
            cls_pkg::CMD_INS_END: begin
              if (is_full) begin
                status_next = cls_pkg::STAT_FULL;
              end else begin
                chain_cmd.op  = cls_pkg::CH_INSERT;
                chain_cmd.idx = cls_pkg::IDXW'(fill);
                fill_next     = fill + cls_pkg::CNTW'(1);
              end
            end
            cls_pkg::CMD_DEL_FRONT: begin
              if (is_empty) begin
                status_next = cls_pkg::STAT_EMPTY;
              end else begin
                chain_cmd.op = cls_pkg::CH_SHIFT_DOWN;
                fill_next    = fill - cls_pkg::CNTW'(1);
              end
            end
            cls_pkg::CMD_DEL_END: begin
              if (is_empty) begin
                status_next = cls_pkg::STAT_EMPTY;
              end else begin
                fill_next = fill - cls_pkg::CNTW'(1);
              end
            end
            cls_pkg::CMD_DUMP: begin
              if (is_empty) begin
                status_next = cls_pkg::STAT_EMPTY;
              end else begin
                // results come from the dump sequencer
                out_valid_next = 1'b0;
                dump_cnt_next  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cls_pkg::ST_DUMP: begin
        // Emit the head cell and rotate the occupied cells by one
        if (out_free) begin
          out_valid_next     = 1'b1;
          status_next        = cls_pkg::STAT_OK;
          element_next       = head_val;
          element_valid_next = 1'b1;
          final_res_next     = dump_last;
          chain_cmd.op       = cls_pkg::CH_ROTATE;
          chain_cmd.idx      = cls_pkg::IDXW'(fill - cls_pkg::CNTW'(1));
          chain_cmd.data     = head_val;
          dump_cnt_next      = dump_cnt + cls_pkg::CNTW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cls_pkg::ST_IDLE;
      fill      <= '0;
      dump_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      dump_cnt  <= dump_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    status_q      <= status_next;
    element       <= element_next;
    element_valid <= element_valid_next;
    final_res     <= final_res_next;
    length        <= cls_pkg::LEN_W'(fill_next);
  end

  assign status = status_q;

endmodule

// ===== src/circular_list_store.sv =====
// Top level of the circular list store: controller plus a row of cells.
// Depends on cls_pkg, cls_ctrl and cls_cell.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | input     | in_valid/in_ready  | command, value, position
//   out     | output    | out_valid/out_ready| status, element, element_valid, length,
//           |           |                    | final_res
//
// Edits and error cases return one result per transaction; a dump of a non-empty list enters
// the dump state and then returns one result per stored element (a single error result when
// empty), rotating the occupied cells one step per result.
// Reset (rst, synchronous) empties the list; cell contents need no clearing pass.
// A new transaction is taken once the result register is empty or in the same cycle
// its result is accepted; a stalled output holds the input, the dump sequencer and the chain.
module circular_list_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cls_pkg::CMD_W-1:0]  command,
  input  logic signed [cls_pkg::DATA_W-1:0] value,
  input  logic [cls_pkg::POS_W-1:0]  position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cls_pkg::STAT_W-1:0] status,
  output logic signed [cls_pkg::DATA_W-1:0] element,
  output logic                       element_valid,
  output logic [cls_pkg::LEN_W-1:0]  length,
  output logic                       final_res
);

  cls_pkg::chain_cmd_t chain_cmd;
  cls_pkg::data_t      cell_val [cls_pkg::CAPACITY];

  // Sequencer and result register
  cls_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .element       (element),
    .element_valid (element_valid),
    .length        (length),
    .final_res     (final_res),
    .head_val      (cell_val[0]),
    .chain_cmd     (chain_cmd)
  );

  // Row of cells, slot 0 at the front
  for (genvar i = 0; i < cls_pkg::CAPACITY; i++) begin : g_cell
    cls_pkg::data_t left_in;
    cls_pkg::data_t right_in;

    if (i == 0) begin : g_first
      assign left_in = chain_cmd.data;
    end else begin : g_left
      assign left_in = cell_val[i-1];
    end

    if (i == cls_pkg::CAPACITY - 1) begin : g_last
      assign right_in = chain_cmd.data;
    end else begin : g_right
      assign right_in = cell_val[i+1];
    end

    cls_cell u_cell (
      .clk       (clk),
      .cmd       (chain_cmd),
      .cell_idx  (cls_pkg::IDXW'(i)),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_val[i])
    );
  end

endmodule

// ===== sim/circular_list_store_test.sv =====
// Self-checking testbench for circular_list_store: random and directed list edits and dumps.
// Depends on cls_pkg and the circular_list_store RTL; a class mirrors the list contents.
module circular_list_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  // command codes that leave the list unchanged (answered with an OK result)
  localparam logic [cls_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [cls_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam cls_pkg::data_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam cls_pkg::data_t VAL_MIN = 32'sh8000_0000;
  localparam int ITEM_TARGET = 320;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  typedef struct {
    cls_pkg::status_t          status;
    cls_pkg::data_t            element;
    logic                      element_valid;
    logic [cls_pkg::LEN_W-1:0] length;
    logic                      final_res;
  } list_result_t;

  // Mirror of the list; turns each accepted command into the results it must produce
  class list_tracker;
    cls_pkg::data_t slots[cls_pkg::CAPACITY];
    int             fill;
    int             errors;
    list_result_t   due_results[$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void push_result(cls_pkg::status_t st, cls_pkg::data_t elem, logic ev,
                              logic last);
      list_result_t r;
      r.status = st;
      r.element = elem;
      r.element_valid = ev;
      r.length = fill[cls_pkg::LEN_W-1:0];
      r.final_res = last;
      due_results.push_back(r);
    endfunction

    // shift cells up from idx and drop the new value in
    function void open_slot(int idx, cls_pkg::data_t v);
      for (int i = fill; i > idx; i--) slots[i] = slots[i-1];
      slots[idx] = v;
      fill++;
    endfunction

    function void take_command(logic [cls_pkg::CMD_W-1:0] cmd, cls_pkg::data_t v,
                               logic [cls_pkg::POS_W-1:0] pos);
      cls_pkg::status_t st;
      st = cls_pkg::STAT_OK;
      case (cmd)
        cls_pkg::CMD_INS_FRONT: begin
          if (fill >= cls_pkg::CAPACITY) st = cls_pkg::STAT_FULL;
          else open_slot(0, v);
        end
        cls_pkg::CMD_INS_AFTER: begin
          // full takes priority over a bad position
          if (fill >= cls_pkg::CAPACITY) st = cls_pkg::STAT_FULL;
          else if (int'(pos) >= fill) st = cls_pkg::STAT_RANGE;
          else open_slot(int'(pos) + 1, v);
        end
        cls_pkg::CMD_INS_END: begin
          if (fill >= cls_pkg::CAPACITY) st = cls_pkg::STAT_FULL;
          else open_slot(fill, v);
        end
        cls_pkg::CMD_DEL_FRONT: begin
          if (fill == 0) st = cls_pkg::STAT_EMPTY;
          else begin
            for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
            fill--;
          end
        end
        cls_pkg::CMD_DEL_END: begin
          if (fill == 0) st = cls_pkg::STAT_EMPTY;
          else fill--;
        end
        cls_pkg::CMD_DUMP: begin
          if (fill == 0) st = cls_pkg::STAT_EMPTY;
          else begin
            for (int i = 0; i < fill; i++)
              push_result(cls_pkg::STAT_OK, slots[i], 1'b1, i == fill - 1);
            return;
          end
        end
        default: ;
      endcase
      push_result(st, '0, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [cls_pkg::STAT_W-1:0] st, cls_pkg::data_t elem,
                               logic ev, logic [cls_pkg::LEN_W-1:0] len, logic last);
      list_result_t r;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d element %0d",
                 $time, st, elem);
        errors++;
        return;
      end
      r = due_results.pop_front();
      compare_field("status", r.status, st);
      compare_field("element", r.element, elem);
      compare_field("element_valid", r.element_valid, ev);
      compare_field("length", r.length, len);
      compare_field("final_res", r.final_res, last);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [cls_pkg::CMD_W-1:0]   command = '0;
  cls_pkg::data_t              value = '0;
  logic [cls_pkg::POS_W-1:0]   position = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [cls_pkg::STAT_W-1:0]  status;
  cls_pkg::data_t              element;
  logic                        element_valid;
  logic [cls_pkg::LEN_W-1:0]   length;
  logic                        final_res;

  bit                          calm = 1'b0;
  list_tracker                 track = new();

  circular_list_store uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .value(value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .element(element), .element_valid(element_valid),
    .length(length), .final_res(final_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cls_pkg::data_t pick_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      default: return cls_pkg::data_t'($urandom);
    endcase
  endfunction

  // position mostly within the current fill so inserts land
  function automatic logic [cls_pkg::POS_W-1:0] pick_position();
    int hi;
    if ($urandom_range(3) == 0) return cls_pkg::POS_W'($urandom_range(15));
    hi = (track.fill > 15) ? 15 : track.fill;
    return cls_pkg::POS_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [cls_pkg::CMD_W-1:0] pick_command(mix_t mix);
    int r;
    r = $urandom_range(99);
    if (r < 3) return ($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    if (r < 13) return cls_pkg::CMD_DUMP;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:   if (r < 80) r = $urandom_range(2); else r = $urandom_range(3, 4);
      MIX_SHRINK: if (r < 80) r = $urandom_range(3, 4); else r = $urandom_range(2);
      default:    r = $urandom_range(4);
    endcase
    case (r)
      0: return cls_pkg::CMD_INS_FRONT;
      1: return cls_pkg::CMD_INS_AFTER;
      2: return cls_pkg::CMD_INS_END;
      3: return cls_pkg::CMD_DEL_FRONT;
      default: return cls_pkg::CMD_DEL_END;
    endcase
  endfunction

  // Drive one input transaction and wait for it to be taken
  task automatic send_item(logic [cls_pkg::CMD_W-1:0] cmd, cls_pkg::data_t v,
                           logic [cls_pkg::POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd;
    value <= v;
    position <= pos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    track.take_command(cmd, v, pos);
  endtask

  // Hold the sender until every outstanding result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (track.pending() != 0) @(posedge clk);
  endtask

  // Result side: check accepted results, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        track.match_result(status, element, element_valid, length, final_res);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: give up after a long stretch with no transaction on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    int sent;
    int phase_len;
    logic [cls_pkg::CMD_W-1:0] cmd;
    mix_t mix;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list errors, single-element deletes, extremes, spare codes
    send_item(cls_pkg::CMD_DUMP, '0, '0);
    send_item(cls_pkg::CMD_DEL_FRONT, '0, '0);
    send_item(cls_pkg::CMD_DEL_END, '0, '0);
    send_item(cls_pkg::CMD_INS_AFTER, 32'sd5, 4'd0);
    send_item(cls_pkg::CMD_INS_FRONT, VAL_MAX, 4'd15);
    send_item(cls_pkg::CMD_DEL_FRONT, '0, '0);
    send_item(cls_pkg::CMD_INS_END, VAL_MIN, '0);
    send_item(cls_pkg::CMD_DEL_END, '0, '0);
    send_item(cls_pkg::CMD_INS_END, -32'sd1, '0);
    send_item(cls_pkg::CMD_INS_FRONT, '0, '0);
    send_item(cls_pkg::CMD_INS_AFTER, 32'sd1234, 4'd0);
    send_item(cls_pkg::CMD_INS_AFTER, -32'sd77, 4'd2);
    send_item(cls_pkg::CMD_INS_AFTER, 32'sd9, 4'd15);
    send_item(CMD_SPARE_6, pick_value(), 4'd15);
    send_item(CMD_SPARE_7, pick_value(), 4'd0);
    send_item(cls_pkg::CMD_DUMP, '0, '0);
    sent = 16;

    // grow to full with random inserts, then hit every full case and dump it all
    while (track.fill < cls_pkg::CAPACITY) begin
      cmd = pick_command(MIX_GROW);
      if (cmd > cls_pkg::CMD_INS_END) cmd = cls_pkg::CMD_INS_AFTER;
      send_item(cmd, pick_value(), pick_position());
      sent++;
    end
    send_item(cls_pkg::CMD_INS_AFTER, pick_value(), 4'd15);
    send_item(cls_pkg::CMD_INS_FRONT, pick_value(), '0);
    send_item(cls_pkg::CMD_INS_END, pick_value(), '0);
    send_item(cls_pkg::CMD_DUMP, '0, '0);
    sent += 4;
    wait_drained();

    // random phases of varying mix and pacing
    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(4) == 0);
      case ($urandom_range(2))
        0: mix = MIX_GROW;
        1: mix = MIX_SHRINK;
        default: mix = MIX_EVEN;
      endcase
      phase_len = $urandom_range(15, 40);
      for (int k = 0; k < phase_len; k++) begin
        send_item(pick_command(mix), pick_value(), pick_position());
        sent++;
      end
      if ($urandom_range(2) == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (track.errors == 0 && track.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
